[rtl/assert_macros.svh]
// Assertion macros shared by the CORDIC cell and the core.
// E2Q_ASSERT checks at every clock edge outside reset.
// E2Q_ASSERT_ALWAYS checks at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define E2Q_ASSERT(lbl, prop, msg)
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/e2q_pkg.sv]
package e2q_pkg;

  // Core sizing
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 14;

  // Port format: Q2.13 angles in, Q1.14 components out
  localparam int IO_W        = 16;
  localparam int OUT_FRAC    = 14;
  localparam int ANGLE_LIMIT = 25736;
  localparam int OUT_ONE     = 16384;

  // Internal widths
  localparam int CW  = FRAC_BITS + 4;
  localparam int MW  = FRAC_BITS + 2;
  localparam int PW  = 2 * MW;
  localparam int SW  = FRAC_BITS + 3;
  localparam int SIW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // Half angle (Q1.14) to FRAC_BITS alignment
  localparam int ZSHL = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int ZSHR = (FRAC_BITS >= OUT_FRAC) ? 0 : OUT_FRAC - FRAC_BITS;
  localparam int ZRND = (ZSHR == 0) ? 0 : (1 << (ZSHR - 1));
  localparam int AW   = IO_W + 1 + ZSHL;

  // FRAC_BITS sum to Q1.14 alignment
  localparam int OSHR = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int OSHL = (FRAC_BITS >= OUT_FRAC) ? 0 : OUT_FRAC - FRAC_BITS;
  localparam int ORND = (OSHR == 0) ? 0 : (1 << (OSHR - 1));
  localparam int EW   = SW + OSHL + 1;

  localparam longint unsigned PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
  localparam longint unsigned GAIN_Q32       = 64'h9B74EDA8;

  // Starting x: CORDIC gain compensation, rounded half up
  localparam logic signed [CW-1:0] GAIN_X =
    CW'((GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FRAC_BITS);

  typedef logic signed [CW-1:0] atan_tab_t [CORDIC_STAGES];

  // One CORDIC lane: cosine, sine and residual angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } lane_t;

  // Everything one cell hands to the next
  typedef struct packed {
    lane_t yaw;
    lane_t pitch;
    lane_t roll;
  } cell_data_t;

  // atan(2^-i) in Q62 (pi/4 constant for i = 0, power series otherwise), rounded half up to FRAC_BITS
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t         tab;
    longint unsigned   acc;
    longint unsigned   term;
    int unsigned       k;
    int unsigned       e;
    int unsigned       i;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        acc = PI_QUARTER_Q62;
      end else begin
        acc = 64'd0;
        k   = 0;
        e   = i;
        while (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k[0]) acc = acc - term;
          else acc = acc + term;
          k = k + 1;
          e = i * (2 * k + 1);
        end
      end
      tab[i] = CW'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  // Clamp an angle to +/-pi and align it as the CORDIC start angle
  function automatic logic signed [CW-1:0] angle_to_z(logic signed [IO_W-1:0] a);
    logic signed [AW-1:0] h;
    h = AW'(a);
    if (h > AW'(ANGLE_LIMIT)) h = AW'(ANGLE_LIMIT);
    else if (h < AW'(-ANGLE_LIMIT)) h = AW'(-ANGLE_LIMIT);
    h = h <<< ZSHL;
    h = h + AW'(ZRND);
    h = h >>> ZSHR;
    return CW'(h);
  endfunction

  // Clamp a CORDIC result to +/-1.0
  function automatic logic signed [MW-1:0] sat_unit(logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = v;
    if (v > ONE_C) r = ONE_C;
    else if (v < -ONE_C) r = -ONE_C;
    return MW'(r);
  endfunction

  // Fixed-point product, rounded half up to FRAC_BITS
  function automatic logic signed [MW-1:0] fmul(logic signed [MW-1:0] a,
                                                logic signed [MW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + PW'(64'd1 << (FRAC_BITS - 1));
    return MW'(p >>> FRAC_BITS);
  endfunction

  // Align a sum to Q1.14 with rounding and clamp to +/-1.0
  function automatic logic signed [IO_W-1:0] to_out(logic signed [SW-1:0] s);
    logic signed [EW-1:0] e;
    e = EW'(s) <<< OSHL;
    e = e + EW'(ORND);
    e = e >>> OSHR;
    if (e > EW'(OUT_ONE)) e = EW'(OUT_ONE);
    else if (e < EW'(-OUT_ONE)) e = EW'(-OUT_ONE);
    return IO_W'(e);
  endfunction

endpackage

[rtl/e2q_cordic_cell.sv]
`include "assert_macros.svh"

module e2q_cordic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [e2q_pkg::SIW-1:0]   stage_i,
  input  logic                      up_valid_i,
  output logic                      up_ready_o,
  input  e2q_pkg::cell_data_t       up_data_i,
  output logic                      dn_valid_o,
  input  logic                      dn_ready_i,
  output e2q_pkg::cell_data_t       dn_data_o
);
  import e2q_pkg::*;

  logic       valid_q, valid_d;
  cell_data_t data_q, data_d;
  logic       load;

  // One micro-rotation toward zero residual angle
  function automatic lane_t rotate(lane_t l, logic [SIW-1:0] s);
    lane_t                r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] a;
    dx = l.y >>> s;
    dy = l.x >>> s;
    a  = ATAN_TAB[s];
    if (!l.z[CW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end
    return r;
  endfunction

  // Take a new request when empty or when the neighbor takes ours
  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    valid_d      = up_ready_o ? up_valid_i : valid_q;
    data_d       = data_q;
    if (load) begin
      data_d.yaw   = rotate(up_data_i.yaw, stage_i);
      data_d.pitch = rotate(up_data_i.pitch, stage_i);
      data_d.roll  = rotate(up_data_i.roll, stage_i);
    end
  end

  // Clear valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  `E2Q_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !valid_q, "cell holds data in reset")
  `E2Q_ASSERT(a_blocked_keeps, valid_q && !dn_ready_i |=> valid_q, "blocked cell lost request")
  `E2Q_ASSERT(a_blocked_data, valid_q && !dn_ready_i |=> $stable(data_q), "blocked cell data moved")

endmodule

[rtl/e2q_quat_mult.sv]
module e2q_quat_mult (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            up_valid_i,
  output logic                            up_ready_o,
  input  e2q_pkg::cell_data_t             up_data_i,
  output logic                            quat_valid_o,
  input  logic                            quat_stall_i,
  output logic signed [e2q_pkg::IO_W-1:0] quat_w_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_x_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_y_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_z_o
);
  import e2q_pkg::*;

  // Roll-pitch products with the yaw terms carried along
  typedef struct packed {
    logic signed [MW-1:0] cr_cp;
    logic signed [MW-1:0] sr_sp;
    logic signed [MW-1:0] sr_cp;
    logic signed [MW-1:0] cr_sp;
    logic signed [MW-1:0] cy;
    logic signed [MW-1:0] sy;
  } pair_t;

  // All eight triple products
  typedef struct packed {
    logic signed [MW-1:0] w_a;
    logic signed [MW-1:0] w_b;
    logic signed [MW-1:0] x_a;
    logic signed [MW-1:0] x_b;
    logic signed [MW-1:0] y_a;
    logic signed [MW-1:0] y_b;
    logic signed [MW-1:0] z_a;
    logic signed [MW-1:0] z_b;
  } triple_t;

  logic    v1_q, v2_q, v3_q;
  logic    r1, r2, r3;
  pair_t   p1_q, p1_d;
  triple_t t2_q, t2_d;
  logic signed [IO_W-1:0] w_q, x_q, y_q, z_q;
  logic signed [IO_W-1:0] w_d, x_d, y_d, z_d;
  logic signed [MW-1:0]   cr, sr, cp, sp;

  // Ready chain from the output register back
  assign r3         = !v3_q || !quat_stall_i;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign up_ready_o = r1;

  // Clamp the CORDIC results and form the roll-pitch products
  always_comb begin
    cr         = sat_unit(up_data_i.roll.x);
    sr         = sat_unit(up_data_i.roll.y);
    cp         = sat_unit(up_data_i.pitch.x);
    sp         = sat_unit(up_data_i.pitch.y);
    p1_d.cr_cp = fmul(cr, cp);
    p1_d.sr_sp = fmul(sr, sp);
    p1_d.sr_cp = fmul(sr, cp);
    p1_d.cr_sp = fmul(cr, sp);
    p1_d.cy    = sat_unit(up_data_i.yaw.x);
    p1_d.sy    = sat_unit(up_data_i.yaw.y);
  end

  // Multiply in the yaw terms
  always_comb begin
    t2_d.w_a = fmul(p1_q.cr_cp, p1_q.cy);
    t2_d.w_b = fmul(p1_q.sr_sp, p1_q.sy);
    t2_d.x_a = fmul(p1_q.sr_cp, p1_q.cy);
    t2_d.x_b = fmul(p1_q.cr_sp, p1_q.sy);
    t2_d.y_a = fmul(p1_q.cr_sp, p1_q.cy);
    t2_d.y_b = fmul(p1_q.sr_cp, p1_q.sy);
    t2_d.z_a = fmul(p1_q.cr_cp, p1_q.sy);
    t2_d.z_b = fmul(p1_q.sr_sp, p1_q.cy);
  end

  // Combine, round to Q1.14 and clamp
  always_comb begin
    w_d = to_out(SW'(t2_q.w_a) + SW'(t2_q.w_b));
    x_d = to_out(SW'(t2_q.x_a) - SW'(t2_q.x_b));
    y_d = to_out(SW'(t2_q.y_a) + SW'(t2_q.y_b));
    z_d = to_out(SW'(t2_q.z_a) - SW'(t2_q.z_b));
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= up_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Stage payloads, held while blocked
  always_ff @(posedge clk_i) begin
    if (r1 && up_valid_i) p1_q <= p1_d;
    if (r2 && v1_q) t2_q <= t2_d;
    if (r3 && v2_q) begin
      w_q <= w_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign quat_valid_o = v3_q;
  assign quat_w_o     = w_q;
  assign quat_x_o     = x_q;
  assign quat_y_o     = y_q;
  assign quat_z_o     = z_q;

endmodule

[rtl/euler_to_quaternion_core.sv]
// Channel   Direction  Handshake                     Payload
// euler     in         euler_valid_i / euler_stall_o yaw_angle_i, pitch_angle_i, roll_angle_i
// quat      out        quat_valid_o / quat_stall_i   quat_w_o, quat_x_o, quat_y_o, quat_z_o
//
// One angle triple accepted per cycle while euler_stall_o is low; each result passes
// through one register per CORDIC cell, then through three multiply and combine
// stages, the last of which is the output register.
// Reset clears only the stage valid bits.
// A stall on the output freezes only the stages behind a full stage, so empty
// slots keep filling and euler_stall_o rises only once every stage holds a request.
`include "assert_macros.svh"

module euler_to_quaternion_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            euler_valid_i,
  output logic                            euler_stall_o,
  input  logic signed [e2q_pkg::IO_W-1:0] yaw_angle_i,
  input  logic signed [e2q_pkg::IO_W-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::IO_W-1:0] roll_angle_i,
  output logic                            quat_valid_o,
  input  logic                            quat_stall_i,
  output logic signed [e2q_pkg::IO_W-1:0] quat_w_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_x_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_y_o,
  output logic signed [e2q_pkg::IO_W-1:0] quat_z_o
);
  import e2q_pkg::*;

  cell_data_t chain_data  [CORDIC_STAGES+1];
  logic       chain_valid [CORDIC_STAGES+1];
  logic       chain_ready [CORDIC_STAGES+1];

  // Seed each lane: gain-compensated x, zero y, clamped half angle
  always_comb begin
    chain_data[0].yaw.x   = GAIN_X;
    chain_data[0].yaw.y   = '0;
    chain_data[0].yaw.z   = angle_to_z(yaw_angle_i);
    chain_data[0].pitch.x = GAIN_X;
    chain_data[0].pitch.y = '0;
    chain_data[0].pitch.z = angle_to_z(pitch_angle_i);
    chain_data[0].roll.x  = GAIN_X;
    chain_data[0].roll.y  = '0;
    chain_data[0].roll.z  = angle_to_z(roll_angle_i);
  end

  assign chain_valid[0] = euler_valid_i;
  assign euler_stall_o  = !chain_ready[0];

  // Row of CORDIC cells, one micro-rotation each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (SIW'(g)),
      .up_valid_i (chain_valid[g]),
      .up_ready_o (chain_ready[g]),
      .up_data_i  (chain_data[g]),
      .dn_valid_o (chain_valid[g+1]),
      .dn_ready_i (chain_ready[g+1]),
      .dn_data_o  (chain_data[g+1])
    );
  end

  // Quaternion products and output register
  e2q_quat_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (chain_valid[CORDIC_STAGES]),
    .up_ready_o   (chain_ready[CORDIC_STAGES]),
    .up_data_i    (chain_data[CORDIC_STAGES]),
    .quat_valid_o (quat_valid_o),
    .quat_stall_i (quat_stall_i),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o)
  );

  `E2Q_ASSERT(a_open_when_drained, !quat_stall_i |-> !euler_stall_o, "stall without backpressure")
  `E2Q_ASSERT(a_stall_needs_result, euler_stall_o |-> quat_valid_o, "stall with empty output")
  `E2Q_ASSERT(a_w_range, quat_valid_o |-> (quat_w_o <= OUT_ONE && quat_w_o >= -OUT_ONE), "w out of range")
  `E2Q_ASSERT(a_z_range, quat_valid_o |-> (quat_z_o <= OUT_ONE && quat_z_o >= -OUT_ONE), "z out of range")

endmodule
